/* design/nsr_pkg.sv */
package nsr_pkg;

    // Field and datapath widths.
    localparam int VALUE_W = 32;
    localparam int X_W     = 31;
    localparam int FRAC_W  = 16;
    localparam int G_W     = 31;
    localparam int DVD_W   = X_W + FRAC_W;
    localparam int SQ_W    = 2 * G_W;
    localparam int ROOT_W  = 24;
    localparam int TOL_W   = 32;

    // Fixed-point constants.
    localparam logic [G_W-1:0]   ONE_Q16   = G_W'(1) << FRAC_W;
    localparam logic [G_W-1:0]   ROOT_MAX  = G_W'((1 << ROOT_W) - 1);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(42950);

    // Divider: one quotient bit per cycle over the whole dividend.
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Datapath operations selected by the control word.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQUARE,
        OP_TEST,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_EMIT
    } op_t;

    // Conditions that hold the sequencer on the current step.
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_NO_REQ,
        HOLD_OUT_BUSY,
        HOLD_DIV_BUSY
    } hold_t;

    // Conditions that take the branch once the step is done.
    typedef enum logic [2:0] {
        BR_NEVER,
        BR_ALWAYS,
        BR_NEG,
        BR_MET,
        BR_LIMIT
    } br_t;

    // Microprogram addresses.
    localparam int UPC_W = 3;
    localparam logic [UPC_W-1:0] A_LOAD   = 3'd0;
    localparam logic [UPC_W-1:0] A_CHKNEG = 3'd1;
    localparam logic [UPC_W-1:0] A_SQUARE = 3'd2;
    localparam logic [UPC_W-1:0] A_TEST   = 3'd3;
    localparam logic [UPC_W-1:0] A_LIMIT  = 3'd4;
    localparam logic [UPC_W-1:0] A_DIV    = 3'd5;
    localparam logic [UPC_W-1:0] A_UPDATE = 3'd6;
    localparam logic [UPC_W-1:0] A_EMIT   = 3'd7;

    typedef struct packed {
        op_t              op;
        hold_t            hold;
        br_t              br;
        logic [UPC_W-1:0] target;
    } ctl_word_t;

    // Divider control from the sequencer.
    typedef struct packed {
        logic init;
        logic step;
    } div_ctl_t;

    // The microprogram. One word per step.
    function automatic ctl_word_t ucode(input logic [UPC_W-1:0] addr);
        ctl_word_t w;
        w = '{op: OP_NOP, hold: HOLD_NONE, br: BR_NEVER, target: A_LOAD};
        unique case (addr)
            A_LOAD:   w = '{op: OP_LOAD,     hold: HOLD_NO_REQ,   br: BR_NEVER,  target: A_LOAD};
            A_CHKNEG: w = '{op: OP_NOP,      hold: HOLD_NONE,     br: BR_NEG,    target: A_EMIT};
            A_SQUARE: w = '{op: OP_SQUARE,   hold: HOLD_NONE,     br: BR_NEVER,  target: A_LOAD};
            A_TEST:   w = '{op: OP_TEST,     hold: HOLD_NONE,     br: BR_MET,    target: A_EMIT};
            A_LIMIT:  w = '{op: OP_DIV_INIT, hold: HOLD_NONE,     br: BR_LIMIT,  target: A_EMIT};
            A_DIV:    w = '{op: OP_DIV_STEP, hold: HOLD_DIV_BUSY, br: BR_NEVER,  target: A_LOAD};
            A_UPDATE: w = '{op: OP_UPDATE,   hold: HOLD_NONE,     br: BR_ALWAYS, target: A_SQUARE};
            A_EMIT:   w = '{op: OP_EMIT,     hold: HOLD_OUT_BUSY, br: BR_ALWAYS, target: A_LOAD};
            default:  w = '{op: OP_NOP,      hold: HOLD_NONE,     br: BR_ALWAYS, target: A_LOAD};
        endcase
        return w;
    endfunction

endpackage

/* design/nsr_divider.sv */
// Restoring divider, one quotient bit per cycle. The quotient is kept to
// the guess width: the divisor never falls below the integer root of the
// dividend, so the true quotient always fits.
module nsr_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  nsr_pkg::div_ctl_t          ctl,
    input  logic [nsr_pkg::DVD_W-1:0]  dividend,
    input  logic [nsr_pkg::G_W-1:0]    divisor,
    output logic [nsr_pkg::G_W-1:0]    quotient,
    output logic                       busy
);

    logic [nsr_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [nsr_pkg::DIV_CNT_W-1:0] cnt_next;
    logic [nsr_pkg::DVD_W-1:0]     dvd_reg;
    logic [nsr_pkg::G_W-1:0]       rem_reg;
    logic [nsr_pkg::G_W-1:0]       quo_reg;
    logic [nsr_pkg::G_W:0]         partial;
    logic [nsr_pkg::G_W+1:0]       trial;
    logic                          fits;

    // Shift in the next dividend bit and try a subtraction.
    assign partial = {rem_reg, dvd_reg[nsr_pkg::DVD_W-1]};
    assign trial   = {1'b0, partial} - {2'b00, divisor};
    assign fits    = ~trial[nsr_pkg::G_W+1];

    // Step counter: the step with a count of one is the last.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.init)
        begin
            cnt_next = nsr_pkg::DIV_CNT_W'(nsr_pkg::DIV_STEPS);
        end
        else if (ctl.step && (cnt_reg != '0))
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Remainder, dividend and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (ctl.step)
        begin
            dvd_reg <= {dvd_reg[nsr_pkg::DVD_W-2:0], 1'b0};
            rem_reg <= fits ? trial[nsr_pkg::G_W-1:0] : partial[nsr_pkg::G_W-1:0];
            quo_reg <= {quo_reg[nsr_pkg::G_W-2:0], fits};
        end
    end

    assign busy     = (cnt_reg != nsr_pkg::DIV_CNT_W'(1));
    assign quotient = quo_reg;

endmodule

/* design/newton_square_root_unit.sv */
// Newton-Raphson square root of a signed Q16.16 radicand, returning an
// unsigned Q16.16 root saturated to 24 bits, with flags for a negative
// radicand and for reaching the iteration bound. One request is worked at
// a time. A non-negative request runs N Newton updates, where N is at most
// MAX_ITERATIONS; each update passes through the limit check, the
// bit-serial divider, which sets the rate, the update, the squaring and
// the tolerance test. A negative request goes straight from the sign
// check to the result. A finished result waits in the output register
// while the next request is already being worked.
module newton_square_root_unit #(
    parameter int MAX_ITERATIONS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [nsr_pkg::TOL_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [nsr_pkg::VALUE_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [nsr_pkg::ROOT_W-1:0]   root,
    output logic                         negative_input,
    output logic                         hit_limit
);

    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

    // Sequencer state.
    logic [nsr_pkg::UPC_W-1:0] upc_reg;
    logic [nsr_pkg::UPC_W-1:0] upc_next;
    nsr_pkg::ctl_word_t        cw;
    logic                      hold_active;
    logic                      br_taken;

    // Datapath registers.
    logic [nsr_pkg::TOL_W-1:0] tol_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic [ITER_W-1:0]         iter_next;
    logic [nsr_pkg::X_W-1:0]   x_reg;
    logic                      neg_reg;
    logic [nsr_pkg::G_W-1:0]   g_reg;
    logic [nsr_pkg::SQ_W-1:0]  sq_reg;
    logic                      done_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [nsr_pkg::ROOT_W-1:0] root_reg;
    logic                      neg_out_reg;
    logic                      hit_out_reg;

    // Datapath wires.
    logic [nsr_pkg::X_W-1:0]   x_in;
    logic [nsr_pkg::DVD_W-1:0] x32;
    logic [nsr_pkg::SQ_W:0]    sq_diff;
    logic                      met;
    logic                      at_limit;
    logic                      accept;
    logic                      out_free;
    logic                      emit;
    logic [nsr_pkg::G_W-1:0]   quotient;
    logic                      div_busy;
    logic [nsr_pkg::G_W:0]     g_sum;
    nsr_pkg::div_ctl_t         div_ctl;

    assign cw = nsr_pkg::ucode(upc_reg);

    // Handshake qualifiers.
    assign in_stall = (upc_reg != nsr_pkg::A_LOAD);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = (cw.op == nsr_pkg::OP_EMIT) && out_free;

    // Radicand in Q15.32 and the tolerance test on g*g - x.
    assign x_in     = value[nsr_pkg::X_W-1:0];
    assign x32      = {x_reg, {nsr_pkg::FRAC_W{1'b0}}};
    assign sq_diff  = {1'b0, sq_reg} - {{(nsr_pkg::SQ_W - nsr_pkg::DVD_W + 1){1'b0}}, x32};
    assign met      = sq_diff[nsr_pkg::SQ_W] ||
                      (sq_diff[nsr_pkg::SQ_W-1:0] <=
                       {{(nsr_pkg::SQ_W - nsr_pkg::TOL_W){1'b0}}, tol_reg});
    assign at_limit = (iter_reg == ITER_W'(MAX_ITERATIONS));

    // Hold conditions.
    always_comb
    begin
        unique case (cw.hold)
            nsr_pkg::HOLD_NONE:     hold_active = 1'b0;
            nsr_pkg::HOLD_NO_REQ:   hold_active = !in_valid;
            nsr_pkg::HOLD_OUT_BUSY: hold_active = !out_free;
            nsr_pkg::HOLD_DIV_BUSY: hold_active = div_busy;
            default:                hold_active = 1'b0;
        endcase
    end

    // Branch conditions.
    always_comb
    begin
        unique case (cw.br)
            nsr_pkg::BR_NEVER:  br_taken = 1'b0;
            nsr_pkg::BR_ALWAYS: br_taken = 1'b1;
            nsr_pkg::BR_NEG:    br_taken = neg_reg;
            nsr_pkg::BR_MET:    br_taken = met;
            nsr_pkg::BR_LIMIT:  br_taken = at_limit;
            default:            br_taken = 1'b0;
        endcase
    end

    // Next step address.
    always_comb
    begin
        priority if (hold_active)
        begin
            upc_next = upc_reg;
        end
        else if (br_taken)
        begin
            upc_next = cw.target;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    // Iteration counter.
    always_comb
    begin
        iter_next = iter_reg;
        if (accept)
        begin
            iter_next = '0;
        end
        else if (cw.op == nsr_pkg::OP_UPDATE)
        begin
            iter_next = iter_reg + 1'b1;
        end
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= nsr_pkg::A_LOAD;
            iter_reg      <= '0;
            tol_reg       <= nsr_pkg::TOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    // Divider control.
    assign div_ctl.init = (cw.op == nsr_pkg::OP_DIV_INIT);
    assign div_ctl.step = (cw.op == nsr_pkg::OP_DIV_STEP);

    nsr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (x32),
        .divisor  (g_reg),
        .quotient (quotient),
        .busy     (div_busy)
    );

    // Newton update: g = (g + x/g) / 2.
    assign g_sum = {1'b0, g_reg} + {1'b0, quotient};

    // Radicand, guess, square and stop flag.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= x_in;
            neg_reg  <= value[nsr_pkg::VALUE_W-1];
            g_reg    <= (x_in > nsr_pkg::ONE_Q16) ? x_in : nsr_pkg::ONE_Q16;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cw.op == nsr_pkg::OP_SQUARE)
            begin
                sq_reg <= nsr_pkg::SQ_W'(g_reg) * nsr_pkg::SQ_W'(g_reg);
            end
            if (cw.op == nsr_pkg::OP_TEST)
            begin
                done_reg <= met;
            end
            if (cw.op == nsr_pkg::OP_UPDATE)
            begin
                g_reg <= g_sum[nsr_pkg::G_W:1];
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (neg_reg)
            begin
                root_reg    <= '0;
                neg_out_reg <= 1'b1;
                hit_out_reg <= 1'b0;
            end
            else
            begin
                root_reg    <= (g_reg > nsr_pkg::ROOT_MAX) ? '1 : g_reg[nsr_pkg::ROOT_W-1:0];
                neg_out_reg <= 1'b0;
                hit_out_reg <= !done_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign root           = root_reg;
    assign negative_input = neg_out_reg;
    assign hit_limit      = hit_out_reg;

`ifndef NO_ASSERTIONS
    // The divider step is entered only from the limit check or itself.
    assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == nsr_pkg::A_DIV) |->
            ($past(upc_reg) == nsr_pkg::A_DIV || $past(upc_reg) == nsr_pkg::A_LIMIT))
        else $error("divide step entered out of sequence");

    // The iteration count never passes its bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        iter_reg <= ITER_W'(MAX_ITERATIONS))
        else $error("iteration count past its bound");

    // Each Newton update never raises the guess.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == nsr_pkg::OP_UPDATE) |=> (g_reg <= $past(g_reg)))
        else $error("Newton update raised the guess");

    // A negative radicand gives a zero root and no limit flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && negative_input) |-> (root == '0 && !hit_limit))
        else $error("bad result for negative radicand");
`endif

endmodule
